// File: src/gcfs_pkg.sv
// ----------------------------------------------------------------------------
// gcfs_pkg
// Shared constants, register codes and reset values for the Gipps
// car-following step block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcfs_pkg;

	// fixed point: every quantity counts units of 2^-FRAC_BITS
	localparam int FRAC_BITS = 8;
	localparam int FIX_ONE   = 1 << FRAC_BITS;
	// 0.025 in fixed point, halves rounded up
	localparam int SQRT_OFS  = (FIX_ONE + 20) / 40;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 192;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_ACCEL      = 3'd0,
		REG_REACTION_TIME  = 3'd1,
		REG_DESIRED_SPEED  = 3'd2,
		REG_OWN_BRAKING    = 3'd3,
		REG_STANDSTILL_GAP = 3'd4,
		REG_LEADER_BRAKING = 3'd5
	} cfg_reg_t;

	localparam logic        [11:0] RST_MAX_ACCEL      = 12'd435;
	localparam logic        [11:0] RST_REACTION_TIME  = 12'd171;
	localparam logic        [15:0] RST_DESIRED_SPEED  = 16'd5120;
	localparam logic signed [12:0] RST_OWN_BRAKING    = -13'sd768;
	localparam logic        [14:0] RST_STANDSTILL_GAP = 15'd1664;
	localparam logic signed [12:0] RST_LEADER_BRAKING = -13'sd896;

endpackage

`default_nettype wire

// File: src/gcfs_delay.sv
// ----------------------------------------------------------------------------
// gcfs_delay
// Shift line that keeps side data aligned with the long arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

module gcfs_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				tap_q[k] <= '0;
			end
		end else if (en) begin
			tap_q[0] <= din;
			for (int k = 1; k < N; k++) begin
				tap_q[k] <= tap_q[k-1];
			end
		end
	end

	assign dout = tap_q[N-1];

endmodule

`default_nettype wire

// File: src/gcfs_div.sv
// ----------------------------------------------------------------------------
// gcfs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// NW stages; the divisor must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module gcfs_div #(
	parameter int NW = 24,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [DW-1:0] rem_st [NW-1];
	logic [DW-1:0] den_st [NW-1];
	logic [NW-1:0] nq_st  [NW];

	for (genvar i = 0; i < NW; i++) begin : g_step
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [NW-1:0] nq_in;
		logic [DW:0]   trial;
		logic          ge;

		if (i == 0) begin : g_head
			assign rem_in = '0;
			assign den_in = den;
			assign nq_in  = num;
		end else begin : g_tail
			assign rem_in = rem_st[i-1];
			assign den_in = den_st[i-1];
			assign nq_in  = nq_st[i-1];
		end

		assign trial = {rem_in, nq_in[NW-1]};
		assign ge    = trial >= {1'b0, den_in};

		// dividend bits leave at the top, quotient bits enter at the bottom
		always_ff @(posedge clk) begin
			if (en) begin
				nq_st[i] <= {nq_in[NW-2:0], ge};
			end
		end

		if (i < NW-1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					rem_st[i] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
					den_st[i] <= den_in;
				end
			end
		end
	end

	assign quo = nq_st[NW-1];

endmodule

`default_nettype wire

// File: src/gcfs_sqrt.sv
// ----------------------------------------------------------------------------
// gcfs_sqrt
// Pipelined floor square root, two radicand bits per stage.
// Built from W/2 stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gcfs_sqrt #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   rad,
	output logic [W/2-1:0] root
);

	localparam int H = W / 2;

	logic [H-1:0] rem_st  [H-1];
	logic [W-1:0] x_st    [H-1];
	logic [H-1:0] root_st [H];

	for (genvar i = 0; i < H; i++) begin : g_step
		logic [H-1:0] rem_in;
		logic [H-1:0] root_in;
		logic [W-1:0] x_in;
		logic [H+1:0] cand;
		logic [H+1:0] trial;
		logic         ge;

		if (i == 0) begin : g_head
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = rad;
		end else begin : g_tail
			assign rem_in  = rem_st[i-1];
			assign root_in = root_st[i-1];
			assign x_in    = x_st[i-1];
		end

		assign cand  = {rem_in, x_in[W-1:W-2]};
		assign trial = {root_in, 2'b01};
		assign ge    = cand >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_st[i] <= {root_in[H-2:0], ge};
			end
		end

		if (i < H-1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					rem_st[i] <= ge ? H'(cand - trial) : cand[H-1:0];
					x_st[i]   <= {x_in[W-3:0], 2'b00};
				end
			end
		end
	end

	assign root = root_st[H-1];

endmodule

`default_nettype wire

// File: src/gipps_car_following_step_top.sv
// ----------------------------------------------------------------------------
// gipps_car_following_step_top
// Gipps car-following acceleration plus left/right lane-change permissions.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | content
//  ----------+-----------+------------------------+---------------------------
//  s_*       | in        | s_tvalid / s_tready    | vehicle positions, speeds
//  m_*       | out       | m_tvalid / m_tready    | acceleration, change flags
//  cfg_*     | in        | cfg_valid / cfg_ready  | register index and value
//
//  One item enters per cycle while the output skid is empty. The pipeline depth
//  is set by the braking chain, in stages: leader speed-squared divider
//  (32), braking radicand square root (24) and the final divide by the
//  reaction time (28), plus glue stages. The free-flow branch (speed ratio
//  divider, square root, two multipliers) runs beside it and is delayed to meet it.
//  Reset clears the valid line and the output skid; registers take reset values.
//  A stalled output fills a one-entry skid; only then does the whole pipeline
//  hold and s_tready drop. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module gipps_car_following_step_top
	import gcfs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// fields from bit 0: follower_position(31), follower_speed(16),
	// leader_position(31), leader_speed(16), new_leader_position(31),
	// new_leader_speed(16), new_follower_position(31), new_follower_speed(16),
	// zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// fields from bit 0: new_leader_present, new_follower_present
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// fields from bit 0: acceleration(16), left_change_ok, right_change_ok,
	// zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// ---------------------------------------------------------------- config
	logic        [11:0] max_accel_q;
	logic        [11:0] reaction_time_q;
	logic        [15:0] desired_speed_q;
	logic signed [12:0] own_braking_q;
	logic        [14:0] standstill_gap_q;
	logic signed [12:0] leader_braking_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_accel_q      <= RST_MAX_ACCEL;
			reaction_time_q  <= RST_REACTION_TIME;
			desired_speed_q  <= RST_DESIRED_SPEED;
			own_braking_q    <= RST_OWN_BRAKING;
			standstill_gap_q <= RST_STANDSTILL_GAP;
			leader_braking_q <= RST_LEADER_BRAKING;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_ACCEL:      max_accel_q      <= cfg_data[11:0];
				REG_REACTION_TIME:  reaction_time_q  <= cfg_data[11:0];
				REG_DESIRED_SPEED:  desired_speed_q  <= cfg_data[15:0];
				REG_OWN_BRAKING:    own_braking_q    <= $signed(cfg_data[12:0]);
				REG_STANDSTILL_GAP: standstill_gap_q <= cfg_data[14:0];
				REG_LEADER_BRAKING: leader_braking_q <= $signed(cfg_data[12:0]);
				default: ;
			endcase
		end
	end

	// zero tau / vn act as 1, zero braking acts as -1
	logic        [11:0] tau_e;
	logic        [15:0] vn_e;
	logic signed [12:0] bn_e;
	logic signed [12:0] bg_e;
	logic        [12:0] bn_abs;
	logic        [12:0] bg_abs;
	logic               bn_neg;
	logic               bg_neg;

	assign tau_e  = (reaction_time_q == '0) ? 12'd1 : reaction_time_q;
	assign vn_e   = (desired_speed_q == '0) ? 16'd1 : desired_speed_q;
	assign bn_e   = (own_braking_q == '0) ? -13'sd1 : own_braking_q;
	assign bg_e   = (leader_braking_q == '0) ? -13'sd1 : leader_braking_q;
	assign bn_neg = bn_e[12];
	assign bg_neg = bg_e[12];
	assign bn_abs = bn_neg ? (~bn_e + 13'd1) : bn_e;
	assign bg_abs = bg_neg ? (~bg_e + 13'd1) : bg_e;

	// config-only terms; the user must change config only while idle (unenforced)
	logic        [23:0] at_prod;
	logic signed [25:0] bt_prod;
	logic signed [25:0] bt_adj;
	logic        [15:0] t_q;
	logic signed [17:0] bt_q;
	logic signed [35:0] bt2_q;

	assign at_prod = max_accel_q * tau_e;
	assign bt_prod = bn_e * $signed({1'b0, tau_e});
	assign bt_adj  = bt_prod + (bt_prod[25] ? 26'sd255 : 26'sd0);

	always_ff @(posedge clk) begin
		t_q   <= at_prod[FRAC_BITS +: 16];
		bt_q  <= bt_adj[25:FRAC_BITS];
		bt2_q <= bt_q * bt_q;
	end

	// ------------------------------------------------------------- handshake
	logic        adv;
	logic        skid_v_q;
	logic [17:0] skid_q;
	logic        vld_s1;
	logic        vld_s92;

	// advance the whole pipeline unless the skid holds a stalled result
	assign adv      = !skid_v_q;
	assign s_tready = adv;

	// ------------------------------------------------------------- stage 1
	logic [30:0] in_xf, in_xl, in_xnl, in_xnf;
	logic [15:0] in_v, in_vl, in_vnl, in_vnf;

	assign in_xf  = s_tdata[30:0];
	assign in_v   = s_tdata[46:31];
	assign in_xl  = s_tdata[77:47];
	assign in_vl  = s_tdata[93:78];
	assign in_xnl = s_tdata[124:94];
	assign in_vnl = s_tdata[140:125];
	assign in_xnf = s_tdata[171:141];
	assign in_vnf = s_tdata[187:172];

	logic signed [33:0] dxl_c;
	logic [31:0] vl2_c, vnl2_c, v2_c, vnf2_c;
	logic [27:0] vtau_c, vnftau_c;

	assign dxl_c    = $signed({3'b0, in_xl}) - $signed({19'b0, standstill_gap_q})
	                  - $signed({3'b0, in_xf});
	assign vl2_c    = in_vl * in_vl;
	assign vnl2_c   = in_vnl * in_vnl;
	assign v2_c     = in_v * in_v;
	assign vnf2_c   = in_vnf * in_vnf;
	assign vtau_c   = in_v * tau_e;
	assign vnftau_c = in_vnf * tau_e;

	logic        [15:0] v_s1;
	logic        [31:0] vl2_s1, vnl2_s1, v2_s1, vnf2_s1;
	logic        [27:0] vtau_s1, vnftau_s1;
	logic signed [34:0] gapc_s1;
	logic signed [33:0] gl_s1, gf_s1;
	logic               nl_s1, nf_s1;
	logic        [1:0]  spd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1      <= in_v;
			vl2_s1    <= vl2_c;
			vnl2_s1   <= vnl2_c;
			v2_s1     <= v2_c;
			vnf2_s1   <= vnf2_c;
			vtau_s1   <= vtau_c;
			vnftau_s1 <= vnftau_c;
			gapc_s1   <= {dxl_c, 1'b0};
			gl_s1     <= $signed({3'b0, in_xnl}) - $signed({19'b0, standstill_gap_q})
			             - $signed({3'b0, in_xf});
			gf_s1     <= $signed({3'b0, in_xf}) - $signed({19'b0, standstill_gap_q})
			             - $signed({3'b0, in_xnf});
			nl_s1     <= s_tuser[0];
			nf_s1     <= s_tuser[1];
			// speed thresholds: below 0.9 vn for left, above 0.95 vn for right
			spd_s1[0] <= (20'(in_v) * 20'd10) < (20'(vn_e) * 20'd9);
			spd_s1[1] <= (21'(in_v) * 21'd20) > (21'(vn_e) * 21'd19);
		end
	end

	// ------------------------------------------------------------- dividers
	logic [23:0] r_s25;
	logic [31:0] qd_s33, qa_s33, qb_s33, qc_s33, qe_s33;

	gcfs_div #(.NW(16 + FRAC_BITS), .DW(16)) u_div_ratio (
		.clk(clk), .en(adv), .num({v_s1, {FRAC_BITS{1'b0}}}), .den(vn_e), .quo(r_s25)
	);
	gcfs_div #(.NW(32), .DW(13)) u_div_lead (
		.clk(clk), .en(adv), .num(vl2_s1), .den(bg_abs), .quo(qd_s33)
	);
	gcfs_div #(.NW(32), .DW(13)) u_div_nl_bg (
		.clk(clk), .en(adv), .num(vnl2_s1), .den(bg_abs), .quo(qa_s33)
	);
	gcfs_div #(.NW(32), .DW(13)) u_div_v_bn (
		.clk(clk), .en(adv), .num(v2_s1), .den(bn_abs), .quo(qb_s33)
	);
	gcfs_div #(.NW(32), .DW(13)) u_div_v_bg (
		.clk(clk), .en(adv), .num(v2_s1), .den(bg_abs), .quo(qc_s33)
	);
	gcfs_div #(.NW(32), .DW(13)) u_div_nf_bn (
		.clk(clk), .en(adv), .num(vnf2_s1), .den(bn_abs), .quo(qe_s33)
	);

	// ------------------------------------------------------------- stage 2
	logic        [29:0] e1_c, e2_c;
	logic signed [35:0] base_s2;
	logic        [20:0] e1_s2, e2_s2;

	assign e1_c = {2'b0, vtau_s1} + {1'b0, vtau_s1, 1'b0};
	assign e2_c = {2'b0, vnftau_s1} + {1'b0, vnftau_s1, 1'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s2 <= 36'(gapc_s1) - $signed({16'b0, vtau_s1[27:FRAC_BITS]});
			e1_s2   <= e1_c[29:FRAC_BITS+1];
			e2_s2   <= e2_c[29:FRAC_BITS+1];
		end
	end

	logic signed [35:0] base_s33;
	logic        [20:0] e1_s33, e2_s33;
	logic signed [33:0] gl_s34, gf_s34;
	logic               nl_s34, nf_s34;
	logic        [1:0]  spd_s34;

	gcfs_delay #(.W(78), .N(31)) u_dly_base (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din({base_s2, e1_s2, e2_s2}), .dout({base_s33, e1_s33, e2_s33})
	);
	gcfs_delay #(.W(72), .N(33)) u_dly_gap (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din({gl_s1, gf_s1, nl_s1, nf_s1, spd_s1}),
		.dout({gl_s34, gf_s34, nl_s34, nf_s34, spd_s34})
	);

	// ------------------------------------------------------------- stage 34
	logic signed [36:0] base_x, qd_x;
	logic signed [34:0] ha, hb, hc, he;
	logic signed [36:0] d_s34;
	logic signed [34:0] es1_s34, es2_s34;

	assign base_x = 37'(base_s33);
	assign qd_x   = $signed({5'b0, qd_s33});
	assign ha     = $signed({4'b0, qa_s33[31:1]});
	assign hb     = $signed({4'b0, qb_s33[31:1]});
	assign hc     = $signed({4'b0, qc_s33[31:1]});
	assign he     = $signed({4'b0, qe_s33[31:1]});

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s34   <= bg_neg ? (base_x + qd_x) : (base_x - qd_x);
			es1_s34 <= $signed({14'b0, e1_s33}) + (bg_neg ? -ha : ha) + (bn_neg ? hb : -hb);
			es2_s34 <= $signed({14'b0, e2_s33}) + (bg_neg ? -hc : hc) + (bn_neg ? he : -he);
		end
	end

	// ------------------------------------------------------------- stage 35
	logic               gap_c;
	logic signed [49:0] bnd_s35;
	logic        [1:0]  lr_s35;

	// an absent vehicle passes its gap test
	assign gap_c = (!nl_s34 || (es1_s34 <= 35'(gl_s34)))
	            && (!nf_s34 || ((gf_s34 > 34'sd0) && (es2_s34 <= 35'(gf_s34))));

	always_ff @(posedge clk) begin
		if (adv) begin
			bnd_s35 <= bn_e * d_s34;
			lr_s35  <= spd_s34 & {2{gap_c}};
		end
	end

	// ------------------------------------------------------------- stage 36
	logic signed [50:0] rad_s36;

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s36 <= 51'(bt2_q) - 51'(bnd_s35);
		end
	end

	logic [23:0] sq2_s60;
	logic        radneg_s60;

	gcfs_sqrt #(.W(48)) u_sqrt_brake (
		.clk(clk), .en(adv), .rad(rad_s36[47:0]), .root(sq2_s60)
	);
	gcfs_delay #(.W(1), .N(24)) u_dly_radneg (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(rad_s36[50]), .dout(radneg_s60)
	);

	// ---------------------------------------------------- free-flow branch
	logic        [31:0] cr_s26;
	logic signed [24:0] omr_s26;
	logic        [23:0] r6_c;

	assign r6_c = r_s25 + 24'(SQRT_OFS);

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s26  <= {r6_c, {FRAC_BITS{1'b0}}};
			omr_s26 <= $signed(25'(FIX_ONE)) - $signed({1'b0, r_s25});
		end
	end

	logic        [15:0] sq_s42;
	logic signed [24:0] omr_s43;

	gcfs_sqrt #(.W(32)) u_sqrt_free (
		.clk(clk), .en(adv), .rad(cr_s26), .root(sq_s42)
	);
	gcfs_delay #(.W(25), .N(17)) u_dly_omr (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(omr_s26), .dout(omr_s43)
	);

	logic        [31:0] p1_s43;
	logic signed [49:0] p2_s44;
	logic signed [49:0] p2_adj;
	logic signed [41:0] w_s45;
	logic signed [44:0] five_w, five_adj;
	logic signed [43:0] half_c;
	logic signed [45:0] vnfl_s46;
	logic        [15:0] v_s45, v_s61;

	assign p2_adj   = p2_s44 + (p2_s44[49] ? 50'sd255 : 50'sd0);
	assign five_w   = (45'(w_s45) <<< 2) + 45'(w_s45);
	assign five_adj = five_w + (five_w[44] ? 45'sd1 : 45'sd0);
	assign half_c   = five_adj[44:1];

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s43   <= t_q * sq_s42;
			p2_s44   <= $signed({1'b0, p1_s43[31:FRAC_BITS]}) * omr_s43;
			w_s45    <= p2_adj[49:FRAC_BITS];
			vnfl_s46 <= 46'(half_c) + $signed({30'b0, v_s45});
		end
	end

	gcfs_delay #(.W(16), .N(44)) u_dly_v_a (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(v_s1), .dout(v_s45)
	);
	gcfs_delay #(.W(16), .N(16)) u_dly_v_b (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(v_s45), .dout(v_s61)
	);

	logic signed [45:0] vnfl_s60;

	gcfs_delay #(.W(46), .N(14)) u_dly_vnfl (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(vnfl_s46), .dout(vnfl_s60)
	);

	// ------------------------------------------------------------- min, diff
	logic signed [25:0] vncg_c;
	logic signed [45:0] vmin_s61;
	logic signed [46:0] diff_s62;
	logic        [46:0] mag_c;
	logic        [19:0] mag_clip;
	logic        [27:0] magn_s63;
	logic               neg_s63;

	assign vncg_c   = 26'(bt_q) + $signed({2'b0, sq2_s60});
	assign mag_c    = diff_s62[46] ? (~diff_s62 + 47'd1) : diff_s62;
	// beyond 2^20 the quotient saturates for any reaction time
	assign mag_clip = (|mag_c[46:20]) ? '1 : mag_c[19:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			// min of braking and free-flow speeds; a negative radicand falls back to free-flow
			vmin_s61 <= (radneg_s60 || (46'(vncg_c) >= vnfl_s60)) ? vnfl_s60 : 46'(vncg_c);
			diff_s62 <= 47'(vmin_s61) - $signed({31'b0, v_s61});
			magn_s63 <= {mag_clip, {FRAC_BITS{1'b0}}};
			neg_s63  <= diff_s62[46];
		end
	end

	logic [27:0] q_s91;
	logic        neg_s91;

	gcfs_div #(.NW(20 + FRAC_BITS), .DW(12)) u_div_tau (
		.clk(clk), .en(adv), .num(magn_s63), .den(tau_e), .quo(q_s91)
	);
	gcfs_delay #(.W(1), .N(28)) u_dly_neg (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(neg_s63), .dout(neg_s91)
	);

	// ------------------------------------------------------------- saturate
	logic [27:0] negq_c;
	logic [15:0] acc_s92;
	logic [1:0]  lr_s92;

	assign negq_c = ~q_s91 + 28'd1;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (neg_s91) begin
				acc_s92 <= (q_s91 > 28'd32768) ? 16'h8000 : negq_c[15:0];
			end else begin
				acc_s92 <= (q_s91 > 28'd32767) ? 16'h7FFF : q_s91[15:0];
			end
		end
	end

	gcfs_delay #(.W(2), .N(57)) u_dly_lr (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(lr_s35), .dout(lr_s92)
	);
	gcfs_delay #(.W(1), .N(91)) u_dly_vld (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(vld_s1), .dout(vld_s92)
	);

	// ------------------------------------------------------------- output skid
	// capture the last stage when the sink stalls; drain on the next transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready) begin
				skid_v_q <= 1'b0;
			end
		end else if (vld_s92 && !m_tready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_q <= {lr_s92, acc_s92};
		end
	end

	assign m_tvalid = skid_v_q || vld_s92;
	assign m_tdata  = {6'b0, (skid_v_q ? skid_q : {lr_s92, acc_s92})};

	// ------------------------------------------------------------- checks
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(vld_s92 && !m_tready))
		else $error("skid filled without a stalled result");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && m_tready |=> !skid_v_q)
		else $error("skid kept a result after its transfer");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s1)
		else $error("accepted item lost its valid bit");

endmodule

`default_nettype wire

// File: dv/gipps_car_following_step_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gipps_car_following_step_top_test
// Self-checking bench for the Gipps car-following step: a directed table and
// random vehicle pairs under several register settings, each result checked
// against a behavioral predictor, with random idling on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module gipps_car_following_step_top_test;
	import gcfs_pkg::*;

	typedef struct packed {
		logic [30:0] fol_pos;
		logic [15:0] fol_spd;
		logic [30:0] lead_pos;
		logic [15:0] lead_spd;
		logic        nl_here;
		logic [30:0] nl_pos;
		logic [15:0] nl_spd;
		logic        nf_here;
		logic [30:0] nf_pos;
		logic [15:0] nf_spd;
	} vehicle_set_t;

	typedef struct packed {
		logic signed [15:0] accel;
		logic               left_ok;
		logic               right_ok;
	} verdict_t;

	typedef struct {
		vehicle_set_t veh;
		bit           typed;
		verdict_t     want;
	} table_row_t;

	localparam int PERIOD_HI   = 2;
	localparam int PERIOD_LO   = 2;
	localparam int DRAIN_WAIT  = 120;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 320;
	localparam int HOLD_CYCLES = 400;
	localparam int VEH_W       = $bits(vehicle_set_t);

	logic                   clk;
	logic                   arst_n;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	gipps_car_following_step_top dut (.*);

	// register shadow used by the predictor
	logic        [11:0] sh_an;
	logic        [11:0] sh_tau;
	logic        [15:0] sh_vn;
	logic signed [12:0] sh_bn;
	logic        [14:0] sh_sn;
	logic signed [12:0] sh_bg;

	verdict_t pending_verdicts[$];
	int       error_count;
	int       items_sent;
	int       results_seen;
	int       settings_run;
	bit       hold_request;
	bit       hold_done;
	bit       quiet_sender;

	// clock: high then low
	initial clk = 1'b0;
	always begin
		#PERIOD_HI clk = 1'b1;
		#PERIOD_LO clk = 1'b0;
	end

	task automatic report_mismatch(string what, longint want, longint got);
		$display("mismatch %s: expected %0d, got %0d (result %0d)", what, want, got,
			results_seen);
		error_count++;
	endtask

	function automatic longint unsigned floor_root(longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x   -= res + bitv;
				res  = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// equilibrium spacing between a lead speed and a following speed
	function automatic longint spacing_needed(longint vl, longint vf, longint tau,
			longint bn, longint bg);
		longint scale;
		scale = FIX_ONE;
		return (3 * vf * tau) / (2 * scale) + (vl * vl) / (2 * bg) - (vf * vf) / (2 * bn);
	endfunction

	function automatic verdict_t predict_gipps(vehicle_set_t vs);
		longint scale, tau, vn, bn, bg, an, sn;
		longint xf, v, xl, vl, xnl, vnl, xnf, vnf;
		longint ratio, root_term, t, u, w, v_free, bt, d, rad, v_min, v_brake, acc;
		bit gaps_ok;
		verdict_t res;
		scale = FIX_ONE;
		tau = (sh_tau == 0) ? 1 : sh_tau;
		vn  = (sh_vn == 0) ? 1 : sh_vn;
		bn  = (sh_bn == 0) ? -1 : sh_bn;
		bg  = (sh_bg == 0) ? -1 : sh_bg;
		an  = sh_an;
		sn  = sh_sn;
		xf  = vs.fol_pos;  v   = vs.fol_spd;
		xl  = vs.lead_pos; vl  = vs.lead_spd;
		xnl = vs.nl_pos;   vnl = vs.nl_spd;
		xnf = vs.nf_pos;   vnf = vs.nf_spd;

		ratio     = (v * scale) / vn;
		root_term = longint'(floor_root(longint'(SQRT_OFS + ratio) * scale));
		t         = (an * tau) / scale;
		u         = (t * root_term) / scale;
		w         = (u * (scale - ratio)) / scale;
		v_free    = v + (5 * w) / 2;

		bt  = (bn * tau) / scale;
		d   = 2 * (xl - sn - xf) - (v * tau) / scale - (vl * vl) / bg;
		rad = bt * bt - bn * d;
		// a negative braking radicand falls back to the free-flow speed
		v_min = v_free;
		if (rad >= 0) begin
			v_brake = bt + longint'(floor_root(rad));
			if (v_brake < v_free) v_min = v_brake;
		end
		acc = ((v_min - v) * scale) / tau;
		if (acc > 32767) acc = 32767;
		if (acc < -32768) acc = -32768;

		gaps_ok = 1'b1;
		if (vs.nl_here && !(xnl - sn >= xf + spacing_needed(vnl, v, tau, bn, bg)))
			gaps_ok = 1'b0;
		if (vs.nf_here && !(xnf + sn < xf &&
				xf - sn >= xnf + spacing_needed(v, vnf, tau, bn, bg)))
			gaps_ok = 1'b0;

		res.accel    = acc[15:0];
		res.left_ok  = (10 * v < 9 * vn) && gaps_ok;
		res.right_ok = (20 * v > 19 * vn) && gaps_ok;
		return res;
	endfunction

	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(99);
		if (pick < 65) return 0;
		if (pick < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// offer one item and hold it until the transfer; keep tvalid high when
	// the next item follows at once
	task automatic offer_item(vehicle_set_t vs, bit typed, verdict_t want);
		int gap;
		verdict_t guess;
		s_tdata  <= {4'b0, vs.nf_spd, vs.nf_pos, vs.nl_spd, vs.nl_pos,
			vs.lead_spd, vs.lead_pos, vs.fol_spd, vs.fol_pos};
		s_tuser  <= {vs.nf_here, vs.nl_here};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		guess = predict_gipps(vs);
		if (typed && guess !== want) begin
			report_mismatch("predictor vs table accel", want.accel, guess.accel);
		end
		pending_verdicts.push_back(typed ? want : guess);
		items_sent++;
		gap = quiet_sender ? 0 : idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold cfg_valid high; the caller drops it after the last write
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MAX_ACCEL:      sh_an  = value[11:0];
			REG_REACTION_TIME:  sh_tau = value[11:0];
			REG_DESIRED_SPEED:  sh_vn  = value;
			REG_OWN_BRAKING:    sh_bn  = value[12:0];
			REG_STANDSTILL_GAP: sh_sn  = value[14:0];
			REG_LEADER_BRAKING: sh_bg  = value[12:0];
			default: ;
		endcase
	endtask

	task automatic load_setting(int an, int tau, int vn, int bn, int sn, int bg);
		// quiet the input, let the pipeline empty, then reprogram
		s_tvalid <= 1'b0;
		wait (pending_verdicts.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		write_reg(REG_MAX_ACCEL, CFG_DATA_W'(an));
		write_reg(REG_REACTION_TIME, CFG_DATA_W'(tau));
		write_reg(REG_DESIRED_SPEED, CFG_DATA_W'(vn));
		write_reg(REG_OWN_BRAKING, CFG_DATA_W'(bn));
		write_reg(REG_STANDSTILL_GAP, CFG_DATA_W'(sn));
		write_reg(REG_LEADER_BRAKING, CFG_DATA_W'(bg));
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	// mostly plausible traffic near the desired speed, some pure noise
	function automatic vehicle_set_t random_traffic();
		vehicle_set_t vs;
		logic [223:0] noise;
		int vref;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		vs = noise[VEH_W-1:0];
		if ($urandom_range(99) < 20) return vs;
		vref = (sh_vn > 2) ? sh_vn : 5120;
		vs.fol_spd  = 16'($urandom_range(vref + vref / 4 > 65535 ? 65535 : vref + vref / 4));
		vs.fol_pos  = 31'($urandom_range(32'h3FFF_FFFF, 32'h0100_0000));
		vs.lead_pos = vs.fol_pos + 31'($urandom_range(40000)) - 31'd2000;
		vs.lead_spd = 16'($urandom_range(vref > 65535 ? 65535 : vref));
		vs.nl_pos   = vs.fol_pos + 31'($urandom_range(60000)) - 31'd5000;
		vs.nl_spd   = 16'($urandom_range(vref > 65535 ? 65535 : vref));
		vs.nf_pos   = vs.fol_pos - 31'($urandom_range(60000)) + 31'd5000;
		vs.nf_spd   = 16'($urandom_range(vref > 65535 ? 65535 : vref));
		return vs;
	endfunction

	function automatic table_row_t row(logic [30:0] fp, logic [15:0] fs, logic [30:0] lp,
			logic [15:0] ls, logic nlh, logic [30:0] nlp, logic [15:0] nls, logic nfh,
			logic [30:0] nfp, logic [15:0] nfs);
		table_row_t r;
		r.veh   = '{fp, fs, lp, ls, nlh, nlp, nls, nfh, nfp, nfs};
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	// result checker: each transfer out against the oldest prediction
	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.accel    = m_tdata[15:0];
			got.left_ok  = m_tdata[16];
			got.right_ok = m_tdata[17];
			if (pending_verdicts.size() == 0) begin
				$display("result with nothing pending (result %0d)", results_seen);
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (got.accel !== want.accel)
					report_mismatch("acceleration", want.accel, got.accel);
				if (got.left_ok !== want.left_ok)
					report_mismatch("left_change_ok", want.left_ok, got.left_ok);
				if (got.right_ok !== want.right_ok)
					report_mismatch("right_change_ok", want.right_ok, got.right_ok);
			end
			results_seen++;
		end
	end

	// receiver: random stalls, free-running stretches, one long hold-off
	initial begin
		int hold;
		int stretch;
		m_tready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				m_tready <= 1'b0;
				for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
				hold_done = 1'b1;
				m_tready <= 1'b1;
			end else if ($urandom_range(99) < 8) begin
				stretch = $urandom_range(60, 20);
				m_tready <= 1'b1;
				repeat (stretch) @(posedge clk);
			end else begin
				m_tready <= (idle_gap() == 0);
			end
		end
	end

	// watchdog: cycles without any transfer
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("gipps_car_following_step_top_test: done, errors");
				$finish;
			end
		end
	end

	initial begin
		table_row_t steps[$];
		table_row_t r;
		vehicle_set_t vs;
		int k;
		int n;

		s_tdata = '0;  s_tuser = '0;  s_tvalid = 1'b0;
		cfg_valid = 1'b0;  cfg_index = REG_MAX_ACCEL;  cfg_data = '0;
		error_count = 0;  items_sent = 0;  results_seen = 0;  settings_run = 0;
		hold_request = 1'b0;  quiet_sender = 1'b0;
		sh_an = RST_MAX_ACCEL;   sh_tau = RST_REACTION_TIME;  sh_vn = RST_DESIRED_SPEED;
		sh_bn = RST_OWN_BRAKING; sh_sn = RST_STANDSTILL_GAP;  sh_bg = RST_LEADER_BRAKING;

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset register values
		// all zero: braking radicand negative, free-flow speed, left allowed
		r = row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		r.typed = 1'b1;  r.want = '{16'sd164, 1'b1, 1'b0};
		steps.push_back(r);
		steps.push_back(row('1, '1, '1, '1, 1, '1, '1, 1, '1, '1));
		steps.push_back(row(1000, 2000, 200000, 2000, 0, 0, 0, 0, 0, 0));
		steps.push_back(row(500000, 3000, 1000, 0, 0, 0, 0, 0, 0, 0));
		// speed above desired, right side threshold
		steps.push_back(row(1000, 6000, 900000, 6000, 0, 0, 0, 0, 0, 0));
		steps.push_back(row(1000, 65535, 1000, 0, 0, 0, 0, 0, 0, 0));
		// new leader close, then far
		steps.push_back(row(10000, 2000, 90000, 2000, 1, 11000, 1000, 0, 0, 0));
		steps.push_back(row(10000, 2000, 90000, 2000, 1, 80000, 3000, 0, 0, 0));
		steps.push_back(row(10000, 5000, 90000, 5000, 1, 99999, 5000, 0, 0, 0));
		// new follower close, ahead of us, far behind
		steps.push_back(row(50000, 2000, 90000, 2000, 0, 0, 0, 1, 49000, 3000));
		steps.push_back(row(50000, 2000, 90000, 2000, 0, 0, 0, 1, 60000, 0));
		steps.push_back(row(50000, 2000, 90000, 2000, 0, 0, 0, 1, 1000, 1000));
		steps.push_back(row(50000, 6000, 90000, 6000, 1, 90000, 6000, 1, 1000, 1000));
		// absent vehicles carry garbage that must be ignored
		steps.push_back(row(50000, 2000, 90000, 2000, 0, '1, '1, 0, '1, '1));
		steps.push_back(row('1, 0, 0, '1, 0, 0, 0, 0, 0, 0));
		steps.push_back(row(0, '1, '1, 0, 1, 0, '1, 1, '1, 0));
		for (k = 0; k < steps.size(); k++)
			offer_item(steps[k].veh, steps[k].typed, steps[k].want);

		// register settings: reset values, both extremes, zero divisors,
		// out-of-range positive braking, then a random one
		for (n = 0; n < 6; n++) begin
			case (n)
				0: load_setting(RST_MAX_ACCEL, RST_REACTION_TIME, RST_DESIRED_SPEED,
					RST_OWN_BRAKING, RST_STANDSTILL_GAP, RST_LEADER_BRAKING);
				1: load_setting(0, 1, 1, -1, 0, -1);
				2: load_setting(2560, 2560, 65535, -2560, 25600, -2560);
				3: load_setting($urandom_range(2560), 0, 0, 0, $urandom_range(25600), 0);
				4: load_setting($urandom_range(2560), $urandom_range(2560, 1),
					$urandom_range(8000, 1000), 100, $urandom_range(25600), 300);
				default: load_setting($urandom_range(2560), $urandom_range(2560, 1),
					$urandom_range(65535, 1), -$urandom_range(2560, 1),
					$urandom_range(25600), -$urandom_range(2560, 1));
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// back-to-back stretch, with the receiver held off in one phase
				quiet_sender = (k >= 100 && k < 220);
				if (n == 2 && k == 100) hold_request = 1'b1;
				vs = random_traffic();
				offer_item(vs, 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		wait (pending_verdicts.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d items over %0d register settings, %0d results checked",
			items_sent, settings_run, results_seen);
		$display("receiver hold-off exercised: %0d", hold_done);
		if (error_count == 0)
			$display("gipps_car_following_step_top_test: done, clean");
		else
			$display("gipps_car_following_step_top_test: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
src/gcfs_pkg.sv
src/gcfs_delay.sv
src/gcfs_div.sv
src/gcfs_sqrt.sv
src/gipps_car_following_step_top.sv
dv/gipps_car_following_step_top_test.sv
